@@ hw/rtl/pdr_pkg.sv @@
// Shared constants and types for the parabolic DAC ramp generator.
package pdr_pkg;

  localparam int VAL_W        = 16;
  localparam int CNT_W        = 16;
  localparam int MULT_W       = 24;
  localparam int CHAN_W       = 4;
  localparam int SUM_W        = VAL_W + 1;
  localparam int PROD_W       = CNT_W + MULT_W;
  localparam int SLOPE_LSB    = 16;
  localparam int DAC_BITS_DEF = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic hit_goal;
    logic last;
  } step_flags_t;

endpackage

@@ hw/rtl/pdr_step.sv @@
// One ramp step: slope product, move toward the goal, and step count update.
module pdr_step #(
  parameter int DAC_BITS = pdr_pkg::DAC_BITS_DEF
) (
  input  logic [DAC_BITS-1:0]      present,
  input  logic [DAC_BITS-1:0]      goal,
  input  logic [pdr_pkg::CNT_W-1:0]  step_count,
  input  logic [pdr_pkg::MULT_W-1:0] curve_factor,
  input  logic                     count_down,
  output logic [DAC_BITS-1:0]      next_present,
  output logic [pdr_pkg::CNT_W-1:0]  next_count,
  output logic [DAC_BITS-1:0]      step_value,
  output pdr_pkg::step_flags_t     flags
);
  import pdr_pkg::*;

  logic [CNT_W-1:0]  odd;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  slope;
  logic [SUM_W-1:0]  pres_ext;
  logic [SUM_W-1:0]  goal_ext;
  logic [SUM_W-1:0]  pres_up;
  logic [SUM_W-1:0]  goal_up;
  logic [SUM_W-1:0]  pres_dn;
  logic              rising;
  logic              hit;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_inc;
  logic              cnt_end;

  assign odd   = {step_count[CNT_W-2:0], 1'b1};
  assign prod  = PROD_W'(odd) * PROD_W'(curve_factor);
  assign slope = prod[SLOPE_LSB +: VAL_W];

  // Sums are kept one bit wider than the values so they never wrap.
  assign pres_ext = SUM_W'(present);
  assign goal_ext = SUM_W'(goal);
  assign pres_up  = pres_ext + SUM_W'(slope);
  assign goal_up  = goal_ext + SUM_W'(slope);
  assign pres_dn  = pres_ext - SUM_W'(slope);
  assign rising   = goal > present;
  assign hit      = rising ? !(goal_ext > pres_up) : !(pres_ext > goal_up);

  assign cnt_dec = step_count - CNT_W'(1);
  assign cnt_inc = step_count + CNT_W'(1);

  always_comb begin
    if (count_down) begin
      // A count that is already zero ends the ramp rather than wrapping.
      next_count = (step_count == '0) ? step_count : cnt_dec;
      cnt_end    = (step_count == '0) || (cnt_dec == '0);
    end else begin
      next_count = cnt_inc;
      cnt_end    = (cnt_inc == '0);
    end
  end

  assign next_present   = hit ? present
                        : (rising ? DAC_BITS'(pres_up) : DAC_BITS'(pres_dn));
  assign step_value     = hit ? goal : next_present;
  assign flags.hit_goal = hit;
  assign flags.last     = hit || cnt_end;

endmodule

@@ hw/rtl/parabolic_dac_ramp.sv @@
// Parabolic DAC ramp generator: start and tick items in, DAC code writes out.
//
// A start item emits its start value on the chosen channel and arms a ramp;
// every tick item while armed emits one step of size (2n+1) times the curvature
// factor, n being the step count (which counts down when inverted), until the
// target is reached or the step count runs out. One item is taken per clock
// while the output is not stalled: each item is held in the input register,
// its step is computed by a single 16x24 multiply and 17-bit compare, and the
// result lands in the output register, from which it transfers when out_ready
// is high. A tick while idle produces no result.
module parabolic_dac_ramp #(
  parameter int DAC_BITS = pdr_pkg::DAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [pdr_pkg::CHAN_W-1:0] in_channel,
  input  logic [pdr_pkg::VAL_W-1:0]  in_start_value,
  input  logic [pdr_pkg::VAL_W-1:0]  in_target_value,
  input  logic [pdr_pkg::MULT_W-1:0] in_multiplier,
  input  logic                       in_invert,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pdr_pkg::CHAN_W-1:0] out_channel,
  output logic [pdr_pkg::VAL_W-1:0]  out_value,
  output logic                       out_last
);
  import pdr_pkg::*;

  // Input register
  logic                in_valid_r;
  logic                cmd_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [VAL_W-1:0]    start_r;
  logic [VAL_W-1:0]    target_r;
  logic [MULT_W-1:0]   mult_r;
  logic                inv_r;

  // Ramp state
  logic                busy_r, busy_nxt;
  logic [DAC_BITS-1:0] present_r, present_nxt;
  logic [DAC_BITS-1:0] goal_r, goal_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MULT_W-1:0]   curve_r, curve_nxt;
  logic                down_r, down_nxt;
  logic [CHAN_W-1:0]   held_chan_r, held_chan_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]   out_chan_r, out_chan_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  logic                advance;
  logic                process;
  logic                load;
  logic [DAC_BITS-1:0] step_present;
  logic [CNT_W-1:0]    step_count;
  logic [DAC_BITS-1:0] step_value;
  step_flags_t         step_flags;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign load     = in_valid && in_ready;
  assign process  = in_valid_r && advance;

  pdr_step #(
    .DAC_BITS(DAC_BITS)
  ) u_step (
    .present      (present_r),
    .goal         (goal_r),
    .step_count   (count_r),
    .curve_factor (curve_r),
    .count_down   (down_r),
    .next_present (step_present),
    .next_count   (step_count),
    .step_value   (step_value),
    .flags        (step_flags)
  );

  always_comb begin
    busy_nxt      = busy_r;
    present_nxt   = present_r;
    goal_nxt      = goal_r;
    count_nxt     = count_r;
    curve_nxt     = curve_r;
    down_nxt      = down_r;
    held_chan_nxt = held_chan_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_chan_nxt  = out_chan_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (process) begin
      if (cmd_r == CMD_START) begin
        held_chan_nxt = chan_r;
        present_nxt   = start_r[DAC_BITS-1:0];
        goal_nxt      = target_r[DAC_BITS-1:0];
        curve_nxt     = mult_r;
        down_nxt      = inv_r;
        if (!inv_r) begin
          count_nxt = '0;
        end
        busy_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
        out_chan_nxt  = chan_r;
        out_value_nxt = VAL_W'(start_r[DAC_BITS-1:0]);
        out_last_nxt  = 1'b0;
      end else if (busy_r) begin
        present_nxt   = step_present;
        // Reaching the goal leaves the count as it was for a later inverted ramp.
        if (!step_flags.hit_goal) begin
          count_nxt = step_count;
        end
        busy_nxt      = !step_flags.last;
        out_valid_nxt = 1'b1;
        out_chan_nxt  = held_chan_r;
        out_value_nxt = VAL_W'(step_value);
        out_last_nxt  = step_flags.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      busy_r      <= 1'b0;
      present_r   <= '0;
      goal_r      <= '0;
      count_r     <= '0;
      curve_r     <= '0;
      down_r      <= 1'b0;
      held_chan_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      busy_r      <= busy_nxt;
      present_r   <= present_nxt;
      goal_r      <= goal_nxt;
      count_r     <= count_nxt;
      curve_r     <= curve_nxt;
      down_r      <= down_nxt;
      held_chan_r <= held_chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r    <= in_command;
      chan_r   <= in_channel;
      start_r  <= in_start_value;
      target_r <= in_target_value;
      mult_r   <= in_multiplier;
      inv_r    <= in_invert;
    end
    out_chan_r  <= out_chan_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_chan_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

endmodule

@@ tb/sv/parabolic_dac_ramp_checker.sv @@
// Transfer monitor, ramp predictor and DAC write scoreboard for the parabolic DAC ramp.
module parabolic_dac_ramp_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_command,
  input  logic [pdr_pkg::CHAN_W-1:0] in_channel,
  input  logic [pdr_pkg::VAL_W-1:0]  in_start_value,
  input  logic [pdr_pkg::VAL_W-1:0]  in_target_value,
  input  logic [pdr_pkg::MULT_W-1:0] in_multiplier,
  input  logic                       in_invert,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [pdr_pkg::CHAN_W-1:0] out_channel,
  input  logic [pdr_pkg::VAL_W-1:0]  out_value,
  input  logic                       out_last,
  output int unsigned                fail_count,
  output int unsigned                pending_count,
  output int unsigned                write_count,
  output int unsigned                ramp_end_count
);
  import pdr_pkg::*;

  typedef struct packed {
    logic              command;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  start_value;
    logic [VAL_W-1:0]  target_value;
    logic [MULT_W-1:0] multiplier;
    logic              invert;
  } ramp_cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
    logic              last;
  } dac_write_t;

  // Shadow copy of the ramp state.
  logic              armed;
  logic [VAL_W-1:0]  level;
  logic [VAL_W-1:0]  goal;
  logic [CNT_W-1:0]  steps;
  logic [MULT_W-1:0] factor;
  logic              counting_down;
  logic [CHAN_W-1:0] chan;

  dac_write_t expected_writes[$];

  initial begin
    fail_count     = 0;
    pending_count  = 0;
    write_count    = 0;
    ramp_end_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at DAC write %0d: %s", write_count, msg);
    fail_count++;
  endtask

  // Applies one command to the shadow state; returns 1 when it produces a DAC write.
  function automatic bit step_ramp(input ramp_cmd_t cmd, output dac_write_t wr);
    logic [CNT_W-1:0] odd;
    logic [31:0]      prod;
    logic [VAL_W-1:0] slope;
    logic             ended;
    wr = '0;
    if (cmd.command == CMD_START) begin
      chan          = cmd.channel;
      level         = cmd.start_value;
      goal          = cmd.target_value;
      factor        = cmd.multiplier;
      counting_down = cmd.invert;
      if (!cmd.invert) begin
        steps = '0;
      end
      armed = 1'b1;
      wr = '{chan, level, 1'b0};
      return 1'b1;
    end
    if (!armed) begin
      return 1'b0;
    end
    // (2n+1) kept at 16 bits, product kept at 32 bits.
    odd   = {steps[CNT_W-2:0], 1'b1};
    prod  = 32'(odd) * 32'(factor);
    slope = prod[SLOPE_LSB +: VAL_W];
    // Sums are compared one bit wider so that they never wrap.
    if (goal > level) begin
      if ({1'b0, goal} > {1'b0, level} + {1'b0, slope}) begin
        level = level + slope;
      end else begin
        armed = 1'b0;
        wr = '{chan, goal, 1'b1};
        return 1'b1;
      end
    end else begin
      if ({1'b0, level} > {1'b0, goal} + {1'b0, slope}) begin
        level = level - slope;
      end else begin
        armed = 1'b0;
        wr = '{chan, goal, 1'b1};
        return 1'b1;
      end
    end
    ended = 1'b0;
    if (counting_down) begin
      if (steps == '0) begin
        ended = 1'b1;
      end else begin
        steps = steps - 1'b1;
        ended = (steps == '0);
      end
    end else begin
      steps = steps + 1'b1;
      ended = (steps == '0);
    end
    if (ended) begin
      armed = 1'b0;
    end
    wr = '{chan, level, ended};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    ramp_cmd_t  cmd;
    dac_write_t wr;
    dac_write_t exp_wr;
    if (!rst_n) begin
      armed         = 1'b0;
      level         = '0;
      goal          = '0;
      steps         = '0;
      factor        = '0;
      counting_down = 1'b0;
      chan          = '0;
      expected_writes.delete();
    end else begin
      if (in_valid && in_ready) begin
        cmd = '{in_command, in_channel, in_start_value, in_target_value, in_multiplier,
                in_invert};
        if (step_ramp(cmd, wr)) begin
          expected_writes.push_back(wr);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write ch %0d value %0d last %0b",
                                    out_channel, out_value, out_last));
        end else begin
          exp_wr = expected_writes.pop_front();
          if (out_channel !== exp_wr.channel) begin
            report_mismatch($sformatf("channel %0d, expected %0d", out_channel,
                                      exp_wr.channel));
          end
          if (out_value !== exp_wr.value) begin
            report_mismatch($sformatf("value %0d, expected %0d", out_value, exp_wr.value));
          end
          if (out_last !== exp_wr.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_wr.last));
          end
          if (exp_wr.last) begin
            ramp_end_count++;
          end
        end
        write_count++;
      end
    end
    pending_count = expected_writes.size();
  end

endmodule

@@ tb/sv/parabolic_dac_ramp_test.sv @@
// Testbench top for the parabolic DAC ramp: stimulus, receiver idling, watchdog and verdict.
module parabolic_dac_ramp_test;
  import pdr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [CHAN_W-1:0] in_channel;
  logic [VAL_W-1:0]  in_start_value;
  logic [VAL_W-1:0]  in_target_value;
  logic [MULT_W-1:0] in_multiplier;
  logic              in_invert;
  logic              out_valid;
  logic              out_ready;
  logic [CHAN_W-1:0] out_channel;
  logic [VAL_W-1:0]  out_value;
  logic              out_last;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned n_writes;
  int unsigned n_ends;
  int unsigned n_starts;
  int unsigned n_ticks;
  int unsigned quiet_cycles;
  bit          burst_tx;
  bit          burst_rx;
  bit          hold_req;

  parabolic_dac_ramp u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_start_value  (in_start_value),
    .in_target_value (in_target_value),
    .in_multiplier   (in_multiplier),
    .in_invert       (in_invert),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_value       (out_value),
    .out_last        (out_last)
  );

  parabolic_dac_ramp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_start_value  (in_start_value),
    .in_target_value (in_target_value),
    .in_multiplier   (in_multiplier),
    .in_invert       (in_invert),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_value       (out_value),
    .out_last        (out_last),
    .fail_count      (n_fail),
    .pending_count   (n_pending),
    .write_count     (n_writes),
    .ramp_end_count  (n_ends)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (burst_tx || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [VAL_W-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return VAL_W'($urandom);
  endfunction

  // Spread the curvature over all magnitudes so that ramps end after few or many steps.
  function automatic logic [MULT_W-1:0] pick_multiplier();
    int unsigned nbits;
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    nbits = $urandom_range(MULT_W, 1);
    return MULT_W'($urandom & ((32'd1 << nbits) - 1));
  endfunction

  task automatic send_item(input int unsigned gap, input logic cmd,
                           input logic [CHAN_W-1:0] ch,
                           input logic [VAL_W-1:0] from_code, to_code,
                           input logic [MULT_W-1:0] mult, input logic inv);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_channel      <= ch;
    in_start_value  <= from_code;
    in_target_value <= to_code;
    in_multiplier   <= mult;
    in_invert       <= inv;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_START) begin
      n_starts++;
    end else begin
      n_ticks++;
    end
  endtask

  // A tick carries random values in the fields that it does not use.
  task automatic send_tick(input int unsigned gap);
    send_item(gap, CMD_TICK, CHAN_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              MULT_W'($urandom), 1'($urandom));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // Receiver: random ready with short and long stalls, stretches of no stall,
  // and one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    int unsigned r;
    stall_left = 0;
    cyc        = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) begin
        burst_rx = ($urandom_range(2, 0) == 0);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (burst_rx) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(2, 0);
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(39, 9);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d writes outstanding",
               quiet_cycles, n_pending);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned seq_len;
    int unsigned sent;
    bit          held;
    bit          paused;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_START;
    in_channel      <= '0;
    in_start_value  <= '0;
    in_target_value <= '0;
    in_multiplier   <= '0;
    in_invert       <= 1'b0;
    hold_req = 1'b0;
    burst_tx = 1'b0;
    burst_rx = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A tick with no ramp armed is dropped.
    send_item(pick_gap(), CMD_TICK, 4'd3, 16'h1234, 16'h4321, 24'h00abcd, 1'b1);
    // Inverted start with a zero step count ends on its first step.
    send_item(pick_gap(), CMD_START, 4'd15, 16'h0000, 16'hffff, 24'hffffff, 1'b1);
    send_item(pick_gap(), CMD_TICK, 4'd0, 16'h0000, 16'h0000, 24'h000000, 1'b0);
    // Zero slope, then a restart while busy onto equal start and target.
    send_item(pick_gap(), CMD_START, 4'd0, 16'hffff, 16'h0000, 24'h000000, 1'b0);
    send_item(pick_gap(), CMD_TICK, 4'd15, 16'hffff, 16'hffff, 24'hffffff, 1'b1);
    send_item(pick_gap(), CMD_TICK, 4'd15, 16'hffff, 16'hffff, 24'hffffff, 1'b1);
    send_item(pick_gap(), CMD_START, 4'd5, 16'd100, 16'd100, 24'h123456, 1'b0);
    send_item(pick_gap(), CMD_TICK, 4'd0, 16'h0000, 16'h0000, 24'h000000, 1'b0);
    // Rising sum past the top of the code range.
    send_item(pick_gap(), CMD_START, 4'd6, 16'd65000, 16'hffff, 24'hffffff, 1'b0);
    send_item(pick_gap(), CMD_TICK, 4'd0, 16'h0000, 16'h0000, 24'h000000, 1'b0);
    send_item(pick_gap(), CMD_TICK, 4'd0, 16'h0000, 16'h0000, 24'h000000, 1'b0);
    // Falling ramp where target plus slope passes the top of the range.
    send_item(pick_gap(), CMD_START, 4'd10, 16'hffff, 16'd65400, 24'hffffff, 1'b0);
    send_item(pick_gap(), CMD_TICK, 4'd0, 16'h0000, 16'h0000, 24'h000000, 1'b0);
    // Build a count of three, then count it down in invert mode.
    send_item(pick_gap(), CMD_START, 4'd1, 16'h0000, 16'hffff, 24'h000001, 1'b0);
    for (k = 0; k < 3; k++) begin
      send_tick(pick_gap());
    end
    send_item(pick_gap(), CMD_START, 4'd2, 16'd1000, 16'h0000, 24'h010000, 1'b1);
    for (k = 0; k < 3; k++) begin
      send_tick(pick_gap());
    end
    send_item(pick_gap(), CMD_TICK, 4'd7, 16'h0f0f, 16'hf0f0, 24'h5a5a5a, 1'b0);

    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(9, 0) == 0) begin
        burst_tx = ~burst_tx;
      end
      if (!held && sent >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && sent >= 650) begin
        idle_input();
        @(posedge clk);
        wait (n_pending == 0);
        @(posedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(99, 0) < 85) begin
        seq_len = $urandom_range(40, 1);
        send_item(pick_gap(), CMD_START, CHAN_W'($urandom), pick_code(), pick_code(),
                  pick_multiplier(), $urandom_range(3, 0) == 0);
        sent++;
        for (k = 0; k < seq_len; k++) begin
          send_tick(pick_gap());
          sent++;
        end
      end else begin
        send_item(pick_gap(), 1'($urandom), CHAN_W'($urandom), pick_code(), pick_code(),
                  pick_multiplier(), 1'($urandom));
        sent++;
      end
    end

    idle_input();
    @(posedge clk);
    wait (n_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d ramp starts and %0d ticks, with idle ticks and restarts.",
             n_starts, n_ticks);
    $display("Checked %0d DAC writes, %0d of which ended a ramp.", n_writes, n_ends);
    if (n_fail == 0 && n_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
